// ===== src/hrsw_pkg.sv =====
// Package: sequencer states, unit codes and fixed-point helpers for the restraint block.
`default_nettype none
package hrsw_pkg;

  localparam logic [47:0] MAX48 = 48'hFFFF_FFFF_FFFF;

  localparam logic [1:0] REG_LAMBDA = 2'd0;
  localparam logic [1:0] REG_RADIUS = 2'd1;
  localparam logic [1:0] REG_WALLK  = 2'd2;

  typedef enum logic [3:0] {
    S_IDLE,
    S_GMUL,
    S_GSQ,
    S_R2,
    S_RR,
    S_SQRT,
    S_WMUL,
    S_DIV,
    S_CMUL,
    S_DD,
    S_EMUL,
    S_FIN,
    S_GE,
    S_OUT
  } state_t;

  typedef enum logic [1:0] {
    RND16,
    RND17,
    RND32
  } rnd_t;

  typedef enum logic {
    SD_SQRT,
    SD_DIV
  } sd_mode_t;

  typedef struct packed {
    logic     start;
    sd_mode_t mode;
  } sd_req_t;

  // round half up by 2^16, 2^17 or 2^32, capped at 48 bits
  function automatic logic [47:0] rnd_cap(input logic [95:0] p, input rnd_t mode);
    logic [96:0] s;
    logic [96:0] q;
    case (mode)
      RND16: begin
        s = {1'b0, p} + (97'd1 << 15);
        q = s >> 16;
      end
      RND17: begin
        s = {1'b0, p} + (97'd1 << 16);
        q = s >> 17;
      end
      default: begin
        s = {1'b0, p} + (97'd1 << 31);
        q = s >> 32;
      end
    endcase
    return (|q[96:48]) ? MAX48 : q[47:0];
  endfunction

  function automatic logic [47:0] add48(input logic [47:0] a, input logic [47:0] b);
    logic [48:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[48] ? MAX48 : s[47:0];
  endfunction

  function automatic logic [31:0] sat32(input logic [51:0] v);
    logic in_range;
    in_range = (&v[51:31]) || !(|v[51:31]);
    if (in_range) begin
      return v[31:0];
    end
    return v[51] ? 32'h8000_0000 : 32'h7FFF_FFFF;
  endfunction

endpackage
`default_nettype wire

// ===== src/hrsw_mul.sv =====
// Iterative 48x48 multiplier, one 48x16 partial product per cycle.
`default_nettype none
module hrsw_mul
  import hrsw_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic [47:0] a,
  input  wire logic [47:0] b,
  output logic             done,
  output logic [95:0]      p
);

  logic [47:0] ar;
  logic [47:0] br;
  logic [95:0] acc;
  logic [1:0]  cnt;
  logic        busy;
  logic [63:0] pp;

  assign pp = 64'(ar) * 64'(br[47:32]);
  assign p  = acc;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= 2'd0;
    end else begin
      done <= 1'b0;
      if (start) begin
        ar   <= a;
        br   <= b;
        acc  <= '0;
        cnt  <= 2'd0;
        busy <= 1'b1;
      end else if (busy) begin
        acc <= (acc << 16) + 96'(pp);
        br  <= br << 16;
        cnt <= cnt + 2'd1;
        if (cnt == 2'd2) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule
`default_nettype wire

// ===== src/hrsw_sqdiv.sv =====
// Shared subtract unit: digit-by-digit square root and restoring divide, one bit a cycle.
`default_nettype none
module hrsw_sqdiv
  import hrsw_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire sd_req_t     req,
  input  wire logic [63:0] opa,
  input  wire logic [31:0] opb,
  output logic             done,
  output logic [32:0]      res
);

  logic [34:0] rem;
  logic [32:0] qr;
  logic [63:0] rad;
  logic [31:0] divr;
  logic [5:0]  cnt;
  logic        busy;
  sd_mode_t    mode;
  logic [34:0] a_in;
  logic [34:0] b_in;
  logic [35:0] diff;
  logic        ge;
  logic        last_step;

  always_comb begin
    if (mode == SD_SQRT) begin
      a_in = {rem[32:0], rad[63:62]};
      b_in = {1'b0, qr[31:0], 2'b01};
    end else begin
      a_in = (cnt == 6'd0) ? {3'b0, rad[31:0]} : {rem[33:0], 1'b0};
      b_in = {3'b0, divr};
    end
    diff      = {1'b0, a_in} - {1'b0, b_in};
    ge        = !diff[35];
    last_step = (mode == SD_SQRT) ? (cnt == 6'd31) : (cnt == 6'd32);
  end

  assign res = qr;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= 6'd0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        mode <= req.mode;
        rem  <= '0;
        qr   <= '0;
        rad  <= opa;
        divr <= opb;
        cnt  <= 6'd0;
        busy <= 1'b1;
      end else if (busy) begin
        rem <= ge ? diff[34:0] : a_in;
        qr  <= {qr[31:0], ge};
        rad <= rad << 2;
        cnt <= cnt + 6'd1;
        if (last_step) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule
`default_nettype wire

// ===== src/harmonic_restraint_and_sphere_wall.sv =====
// Top level: ghost restraint and spherical wall sequencer around the shared units.
// Per atom: ghost force and square for each restrained component, the position squares and
// squared radius, and for an atom outside the sphere a root, wall multiply, a divide and force
// multiply per component and the wall energy, plus the ghost energy on the last atom. One atom
// at a time; the next is taken once the result beat leaves. Synchronous reset clears config,
// sums and sequencer.
`default_nettype none
module harmonic_restraint_and_sphere_wall
  import hrsw_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_tvalid,
  output logic              s_tready,
  // pos_x, pos_y, pos_z, ghost_x, ghost_y, ghost_z, restrain_mask, force_in_x/y/z, pad
  input  wire logic [295:0] s_tdata,
  input  wire logic         s_tlast,
  output logic              m_tvalid,
  input  wire logic         m_tready,
  // force_out_x/y/z, half_sq_offset, ghost_energy, wall_energy, restraint_total
  output logic [287:0]      m_tdata,
  output logic              m_tlast,
  input  wire logic         cfg_we,
  input  wire logic [1:0]   cfg_index,
  input  wire logic [31:0]  cfg_data
);

  state_t state, state_next;

  logic [31:0] lambda;
  logic [30:0] radius;
  logic [31:0] wallk;

  logic [31:0] pos   [3];
  logic [31:0] ghost [3];
  logic [51:0] frc   [3];
  logic [2:0]  mask;
  logic        last;
  logic [1:0]  k;
  logic [1:0]  k_inc;
  logic        launched;

  logic [63:0] r2;
  logic [31:0] dwall;
  logic [47:0] w;
  logic [32:0] u;
  logic [47:0] dd;
  logic [47:0] sum;
  logic [47:0] wsum;

  logic [31:0] fo [3];
  logic [47:0] hso_o, ge_o, we_o, tot_o;
  logic        done_o;

  logic        mul_start, mul_done;
  logic [47:0] mul_a, mul_b;
  logic [95:0] mul_p;
  rnd_t        rmode;
  logic [47:0] rres;
  sd_req_t     sd_req;
  logic [63:0] sd_a;
  logic        sd_done;
  logic [32:0] sd_res;

  logic [32:0] dk;
  logic [32:0] mdk;
  logic [31:0] pmag;
  logic        gskip;
  logic        accept;
  logic        outside;

  hrsw_mul u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .done  (mul_done),
    .p     (mul_p)
  );

  hrsw_sqdiv u_sqdiv (
    .clk  (clk),
    .rst  (rst),
    .req  (sd_req),
    .opa  (sd_a),
    .opb  (dwall + 32'(radius)),
    .done (sd_done),
    .res  (sd_res)
  );

  always_comb begin
    dk      = {ghost[k][31], ghost[k]} - {pos[k][31], pos[k]};
    mdk     = dk[32] ? (33'd0 - dk) : dk;
    pmag    = pos[k][31] ? (32'd0 - pos[k]) : pos[k];
    gskip   = (state == S_GMUL) && !mask[k];
    k_inc   = (k == 2'd2) ? 2'd0 : k + 2'd1;
    accept  = s_tvalid && s_tready;
    rres    = rnd_cap(mul_p, rmode);
    outside = r2 > mul_p[63:0];
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: if (s_tvalid) state_next = S_GMUL;
      S_GMUL: begin
        if (gskip) begin
          state_next = (k == 2'd2) ? S_R2 : S_GMUL;
        end else if (mul_done) begin
          state_next = S_GSQ;
        end
      end
      S_GSQ:  if (mul_done) state_next = (k == 2'd2) ? S_R2 : S_GMUL;
      S_R2:   if (mul_done) state_next = (k == 2'd2) ? S_RR : S_R2;
      S_RR:   if (mul_done) state_next = outside ? S_SQRT : S_FIN;
      S_SQRT: if (sd_done) state_next = S_WMUL;
      S_WMUL: if (mul_done) state_next = S_DIV;
      S_DIV:  if (sd_done) state_next = S_CMUL;
      S_CMUL: if (mul_done) state_next = (k == 2'd2) ? S_DD : S_DIV;
      S_DD:   if (mul_done) state_next = S_EMUL;
      S_EMUL: if (mul_done) state_next = S_FIN;
      S_FIN:  state_next = last ? S_GE : S_OUT;
      S_GE:   if (mul_done) state_next = S_OUT;
      S_OUT:  if (m_tready) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // unit control and handshake
  always_comb begin
    mul_start   = 1'b0;
    mul_a       = '0;
    mul_b       = '0;
    rmode       = RND16;
    sd_req      = '{start: 1'b0, mode: SD_SQRT};
    sd_a        = r2;
    s_tready    = (state == S_IDLE);
    m_tvalid    = (state == S_OUT);
    case (state)
      S_GMUL: begin
        mul_a = 48'(mdk);
        mul_b = 48'(lambda);
      end
      S_GSQ: begin
        mul_a = 48'(mdk);
        mul_b = 48'(mdk);
      end
      S_R2: begin
        mul_a = 48'(pmag);
        mul_b = 48'(pmag);
      end
      S_RR: begin
        mul_a = 48'(radius);
        mul_b = 48'(radius);
      end
      S_WMUL: begin
        mul_a = 48'(wallk);
        mul_b = 48'(dwall);
      end
      S_CMUL: begin
        mul_a = w;
        mul_b = 48'(u);
        rmode = RND32;
      end
      S_DD: begin
        mul_a = 48'(dwall);
        mul_b = 48'(dwall);
      end
      S_EMUL: begin
        mul_a = dd;
        mul_b = 48'(wallk);
        rmode = RND17;
      end
      S_GE: begin
        mul_a = sum;
        mul_b = 48'(lambda);
        rmode = RND17;
      end
      S_SQRT: sd_req.start = !launched;
      S_DIV: begin
        sd_req.start = !launched;
        sd_req.mode  = SD_DIV;
        sd_a         = 64'(pmag);
      end
      default: ;
    endcase
    if ((state == S_GMUL && !gskip) || state == S_GSQ || state == S_R2 ||
        state == S_RR || state == S_WMUL || state == S_CMUL || state == S_DD ||
        state == S_EMUL || state == S_GE) begin
      mul_start = !launched;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      launched <= 1'b0;
      sum      <= '0;
      wsum     <= '0;
      lambda   <= '0;
      radius   <= '0;
      wallk    <= '0;
      k        <= 2'd0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        case (cfg_index)
          REG_LAMBDA: lambda <= cfg_data;
          REG_RADIUS: radius <= cfg_data[30:0];
          REG_WALLK:  wallk  <= cfg_data;
          default: ;
        endcase
      end
      if (mul_start || sd_req.start) begin
        launched <= 1'b1;
      end else if (mul_done || sd_done) begin
        launched <= 1'b0;
      end
      if (accept) begin
        pos[0]   <= s_tdata[31:0];
        pos[1]   <= s_tdata[63:32];
        pos[2]   <= s_tdata[95:64];
        ghost[0] <= s_tdata[127:96];
        ghost[1] <= s_tdata[159:128];
        ghost[2] <= s_tdata[191:160];
        mask     <= s_tdata[194:192];
        frc[0]   <= 52'(signed'(s_tdata[226:195]));
        frc[1]   <= 52'(signed'(s_tdata[258:227]));
        frc[2]   <= 52'(signed'(s_tdata[290:259]));
        last     <= s_tlast;
        k        <= 2'd0;
        r2       <= '0;
        dwall    <= '0;
      end
      case (state)
        S_GMUL: begin
          if (gskip) begin
            k <= k_inc;
          end else if (mul_done) begin
            frc[k] <= dk[32] ? frc[k] + 52'(rres) : frc[k] - 52'(rres);
          end
        end
        S_GSQ: begin
          if (mul_done) begin
            sum <= add48(sum, rres);
            k   <= k_inc;
          end
        end
        S_R2: begin
          if (mul_done) begin
            r2 <= r2 + mul_p[63:0];
            k  <= k_inc;
          end
        end
        S_SQRT: begin
          if (sd_done) begin
            dwall <= (sd_res[31:0] > 32'(radius)) ? sd_res[31:0] - 32'(radius) : 32'd0;
          end
        end
        S_WMUL: if (mul_done) w <= rres;
        S_DIV:  if (sd_done) u <= sd_res;
        S_CMUL: begin
          if (mul_done) begin
            frc[k] <= pos[k][31] ? frc[k] - 52'(rres) : frc[k] + 52'(rres);
            k      <= k_inc;
          end
        end
        S_DD:   if (mul_done) dd <= rres;
        S_EMUL: if (mul_done) wsum <= add48(wsum, rres);
        S_FIN: begin
          fo[0]  <= sat32(frc[0]);
          fo[1]  <= sat32(frc[1]);
          fo[2]  <= sat32(frc[2]);
          hso_o  <= '0;
          ge_o   <= '0;
          we_o   <= '0;
          tot_o  <= '0;
          done_o <= 1'b0;
        end
        S_GE: begin
          if (mul_done) begin
            hso_o  <= 48'(({1'b0, sum} + 49'd1) >> 1);
            ge_o   <= rres;
            we_o   <= wsum;
            tot_o  <= add48(rres, wsum);
            done_o <= 1'b1;
            sum    <= '0;
            wsum   <= '0;
          end
        end
        default: ;
      endcase
    end
  end

  // dwall holds r - R, so the divisor port recovers r without a separate register
  assign m_tdata = {tot_o, we_o, ge_o, hso_o, fo[2], fo[1], fo[0]};
  assign m_tlast = done_o;

  a_one_unit_done: assert property (@(posedge clk) disable iff (rst)
    !(mul_done && sd_done))
    else $error("both shared units finished together");

  a_done_launched: assert property (@(posedge clk) disable iff (rst)
    (mul_done || sd_done) |-> launched)
    else $error("unit finished without a launch");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("second beat taken while atom in flight");

  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(s_tready && m_tvalid))
    else $error("input ready while result pending");

endmodule
`default_nettype wire

// ===== tb/sv/tb.sv =====
// Testbench for the ghost restraint and spherical wall block: directed table plus random frames.
`default_nettype none
module tb;
  import hrsw_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] REG_UNUSED = 2'd3;
  localparam int IDLE_LIMIT = 6000;
  localparam int RAND_ITEMS = 250;

  typedef struct packed {
    logic [2:0][31:0] pos;
    logic [2:0][31:0] ghost;
    logic [2:0]       mask;
    logic [2:0][31:0] fin;
    logic             last;
  } atom_t;

  typedef struct packed {
    logic [2:0][31:0] fout;
    logic [47:0]      half_sq;
    logic [47:0]      ghost_e;
    logic [47:0]      wall_e;
    logic [47:0]      total;
    logic             done;
  } frame_out_t;

  typedef struct packed {
    atom_t a;
    logic  typed;
  } row_t;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [295:0] s_tdata = '0;
  logic         s_tlast = 1'b0;
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [287:0] m_tdata;
  logic         m_tlast;
  logic         cfg_we = 1'b0;
  logic [1:0]   cfg_index = '0;
  logic [31:0]  cfg_data = '0;

  harmonic_restraint_and_sphere_wall uut (.*);

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // predictor copy of the block's registers and sums
  logic [31:0] lam_q, wallk_q;
  logic [30:0] radius_q;
  logic [47:0] sq_sum_q, wall_sum_q;

  frame_out_t expected_q[$];
  bit         failed = 1'b0;
  bit         tx_busy = 1'b1, rx_busy = 1'b1;
  int         idle_cycles = 0;

  function automatic logic [47:0] mul_round(logic [63:0] a, logic [63:0] b, int s);
    logic [128:0] p;
    p = {65'b0, a} * {65'b0, b};
    p = (p + (129'd1 << (s - 1))) >> s;
    return (p > {81'b0, MAX48}) ? MAX48 : p[47:0];
  endfunction

  function automatic logic [47:0] sum_sat(logic [47:0] a, logic [47:0] b);
    logic [48:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[48] ? MAX48 : s[47:0];
  endfunction

  function automatic logic [32:0] floor_root(logic [63:0] v);
    logic [32:0] res, c;
    res = '0;
    for (int i = 32; i >= 0; i--) begin
      c = res | (33'd1 << i);
      if ({33'b0, c} * {33'b0, c} <= {2'b0, v}) res = c;
    end
    return res;
  endfunction

  function automatic logic signed [63:0] sx(logic [31:0] v);
    return $signed({{32{v[31]}}, v});
  endfunction

  function automatic frame_out_t predict_atom(atom_t a);
    frame_out_t o;
    logic signed [63:0] frc[3];
    logic signed [63:0] d;
    logic [63:0] m, r2, rr, r, dd, u;
    logic [47:0] t, w, c, e, ge;
    for (int k = 0; k < 3; k++) frc[k] = sx(a.fin[k]);
    for (int k = 0; k < 3; k++) begin
      if (a.mask[k]) begin
        d = sx(a.ghost[k]) - sx(a.pos[k]);
        m = (d < 0) ? -d : d;
        t = mul_round(m, {32'b0, lam_q}, 16);
        frc[k] = (d < 0) ? frc[k] + $signed({16'b0, t}) : frc[k] - $signed({16'b0, t});
        sq_sum_q = sum_sat(sq_sum_q, mul_round(m, m, 16));
      end
    end
    r2 = '0;
    for (int k = 0; k < 3; k++) begin
      m = sx(a.pos[k]) < 0 ? -sx(a.pos[k]) : sx(a.pos[k]);
      r2 += m * m;
    end
    rr = {33'b0, radius_q} * {33'b0, radius_q};
    if (r2 > rr) begin
      r = {31'b0, floor_root(r2)};
      if (r == 0) r = 1;
      dd = (r > {33'b0, radius_q}) ? r - {33'b0, radius_q} : 64'd0;
      w = mul_round({32'b0, wallk_q}, dd, 16);
      for (int k = 0; k < 3; k++) begin
        m = sx(a.pos[k]) < 0 ? -sx(a.pos[k]) : sx(a.pos[k]);
        u = (m << 32) / r;
        c = mul_round({16'b0, w}, u, 32);
        frc[k] = a.pos[k][31] ? frc[k] - $signed({16'b0, c}) : frc[k] + $signed({16'b0, c});
      end
      e = mul_round({16'b0, mul_round(dd, dd, 16)}, {32'b0, wallk_q}, 17);
      wall_sum_q = sum_sat(wall_sum_q, e);
    end
    for (int k = 0; k < 3; k++) begin
      if (frc[k] > 64'sd2147483647) o.fout[k] = 32'h7FFF_FFFF;
      else if (frc[k] < -64'sd2147483648) o.fout[k] = 32'h8000_0000;
      else o.fout[k] = frc[k][31:0];
    end
    o.half_sq = '0;
    o.ghost_e = '0;
    o.wall_e = '0;
    o.total = '0;
    o.done = a.last;
    if (a.last) begin
      ge = mul_round({16'b0, sq_sum_q}, {32'b0, lam_q}, 17);
      o.half_sq = 48'(({1'b0, sq_sum_q} + 49'd1) >> 1);
      o.ghost_e = ge;
      o.wall_e = wall_sum_q;
      o.total = sum_sat(ge, wall_sum_q);
      sq_sum_q = '0;
      wall_sum_q = '0;
    end
    return o;
  endfunction

  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_LAMBDA: lam_q = val;
      REG_RADIUS: radius_q = val[30:0];
      REG_WALLK:  wallk_q = val;
      default: ;
    endcase
  endtask

  task automatic configure(logic [31:0] lam, logic [31:0] rad, logic [31:0] wk);
    write_reg(REG_LAMBDA, lam);
    write_reg(REG_RADIUS, rad);
    write_reg(REG_WALLK, wk);
  endtask

  task automatic send_atom(atom_t a, logic typed);
    int gap;
    frame_out_t o;
    gap = tx_busy ? $urandom_range(0, 17) : 0;
    @(negedge clk);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tlast <= a.last;
    s_tdata <= {5'b0, a.fin[2], a.fin[1], a.fin[0], a.mask,
                a.ghost[2], a.ghost[1], a.ghost[0], a.pos[2], a.pos[1], a.pos[0]};
    do @(posedge clk); while (!s_tready);
    o = predict_atom(a);
    if (typed) begin
      o.fout = a.fin;
      o.half_sq = '0;
      o.ghost_e = '0;
      o.wall_e = '0;
      o.total = '0;
      o.done = a.last;
    end
    expected_q.push_back(o);
  endtask

  // waits until the block has returned every result and gone quiet
  task automatic settle();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  function automatic atom_t rand_atom(logic [31:0] span);
    atom_t a;
    for (int k = 0; k < 3; k++) begin
      if ($urandom_range(0, 3) == 0) begin
        a.pos[k] = $urandom;
        a.ghost[k] = $urandom;
        a.fin[k] = $urandom;
      end else begin
        a.pos[k] = $urandom_range(0, 2 * span) - span;
        a.ghost[k] = a.pos[k] + $urandom_range(0, 32'h0008_0000) - 32'h0004_0000;
        a.fin[k] = $urandom_range(0, 32'h0100_0000) - 32'h0080_0000;
      end
    end
    a.mask = $urandom_range(0, 7);
    a.last = ($urandom_range(0, 7) == 0);
    return a;
  endfunction

  task automatic check_field(string name, logic [47:0] exp_v, logic [47:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %h, got %h", name, exp_v, act_v);
      failed = 1'b1;
    end
  endtask

  // result side: random stalls, checks at the accepting edge
  initial begin
    int gap;
    frame_out_t e;
    forever begin
      gap = rx_busy ? $urandom_range(0, 17) : 0;
      if (gap > 0) begin
        @(negedge clk);
        m_tready <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
      @(negedge clk);
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
      if (expected_q.size() == 0) begin
        $error("result beat with nothing expected");
        failed = 1'b1;
      end else begin
        e = expected_q.pop_front();
        check_field("force_out_x", 48'(e.fout[0]), 48'(m_tdata[31:0]));
        check_field("force_out_y", 48'(e.fout[1]), 48'(m_tdata[63:32]));
        check_field("force_out_z", 48'(e.fout[2]), 48'(m_tdata[95:64]));
        check_field("half_sq_offset", e.half_sq, m_tdata[143:96]);
        check_field("ghost_energy", e.ghost_e, m_tdata[191:144]);
        check_field("wall_energy", e.wall_e, m_tdata[239:192]);
        check_field("restraint_total", e.total, m_tdata[287:240]);
        check_field("frame_done", 48'(e.done), 48'(m_tlast));
      end
    end
  end

  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we || rst) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > IDLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  row_t table_rows[$];

  function automatic atom_t mk(logic [31:0] px, logic [31:0] py, logic [31:0] pz,
                               logic [31:0] gx, logic [31:0] gy, logic [31:0] gz,
                               logic [2:0] mask, logic [31:0] f, logic last);
    atom_t a;
    a.pos = {pz, py, px};
    a.ghost = {gz, gy, gx};
    a.mask = mask;
    a.fin = {~f, f, f ^ 32'h5A5A_5A5A};
    a.last = last;
    return a;
  endfunction

  initial begin
    logic [31:0] cfgs[6][3];
    lam_q = '0;
    radius_q = '0;
    wallk_q = '0;
    sq_sum_q = '0;
    wall_sum_q = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // all registers zero after reset: force passes straight through
    table_rows.push_back('{mk(32'h7FFF_FFFF, 0, 0, 0, 0, 0, 3'd0, 32'h7FFF_FFFF, 0), 1'b1});
    table_rows.push_back('{mk(32'h8000_0000, 0, 0, 0, 0, 0, 3'd0, 32'h8000_0000, 0), 1'b1});
    table_rows.push_back('{mk(0, 0, 0, 0, 0, 0, 3'd0, 32'h0000_0000, 0), 1'b1});
    table_rows.push_back('{mk(1, 2, 3, 4, 5, 6, 3'd0, 32'hFFFF_FFFF, 1), 1'b1});
    foreach (table_rows[i]) send_atom(table_rows[i].a, table_rows[i].typed);
    settle();
    table_rows.delete();

    write_reg(REG_UNUSED, 32'hFFFF_FFFF);
    configure(32'h0001_0000, 32'h8005_0000, 32'h0002_0000);
    for (int k = 1; k < 8; k++)
      table_rows.push_back('{mk(32'h0001_0000, 0, 0, 32'h0003_0000, 32'hFFFF_0000,
                               32'h0000_8000, 3'(k), 32'h0000_1000, k == 7), 1'b0});
    table_rows.push_back('{mk(32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 0, 0, 0,
                             3'd7, 0, 0), 1'b0});
    table_rows.push_back('{mk(32'h0005_0000, 0, 0, 32'h0005_0000, 0, 0, 3'd7, 0, 0), 1'b0});
    table_rows.push_back('{mk(0, 32'hFFFB_0000, 0, 0, 0, 0, 3'd0, 32'h7FFF_0000, 0), 1'b0});
    table_rows.push_back('{mk(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                             32'h7FFF_FFFF, 32'h8000_0000, 3'd7, 32'h7FFF_FFFF, 0), 1'b0});
    table_rows.push_back('{mk(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF,
                             32'h7FFF_FFFF, 32'h7FFF_FFFF, 3'd7, 32'h8000_0000, 1), 1'b0});
    table_rows.push_back('{mk(0, 0, 0, 0, 0, 0, 3'd0, 0, 1), 1'b0});
    foreach (table_rows[i]) send_atom(table_rows[i].a, table_rows[i].typed);
    settle();

    cfgs[0] = '{32'h0001_0000, 32'h0014_0000, 32'h0004_0000};
    cfgs[1] = '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF};
    cfgs[2] = '{32'h0000_0000, 32'h0000_0000, 32'h0000_0000};
    cfgs[3] = '{32'h0000_4000, 32'h0010_0000, 32'h0064_0000};
    cfgs[4] = '{32'h0000_0000, 32'h0000_0000, 32'hFFFF_FFFF};
    cfgs[5] = '{32'h0000_0001, 32'h0000_0001, 32'h0000_0001};
    for (int ph = 0; ph < 6; ph++) begin
      if (ph == 0) configure($urandom, $urandom, $urandom);
      else configure(cfgs[ph][0], cfgs[ph][1], cfgs[ph][2]);
      tx_busy = (ph % 3) != 1;
      rx_busy = (ph % 3) != 2;
      for (int i = 0; i < RAND_ITEMS; i++)
        send_atom(rand_atom(32'h0020_0000), 1'b0);
      settle();
    end
    tx_busy = 1'b1;
    rx_busy = 1'b1;
    repeat (250) @(posedge clk);
    if (!failed) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
`default_nettype wire
